// ----- hdl/pgte_pkg.sv -----
// Shared types, constants and AES helper functions for the punctured GGM tree expander.
// Used by pgte_aes and punctured_ggm_tree_expand; no dependencies.
package pgte_pkg;

  // Configuration register indexes
  localparam logic [1:0] CfgKeyLo  = 2'd0;
  localparam logic [1:0] CfgKeyHi  = 2'd1;
  localparam logic [1:0] CfgActive = 2'd2;

  // Fixed field widths
  localparam int unsigned WordW  = 64;
  localparam int unsigned BlockW = 128;
  localparam int unsigned SizeW  = 7;
  localparam int unsigned LvlW   = 3;
  localparam int unsigned IdxW   = 6;
  localparam int unsigned RoundW = 4;
  localparam logic [RoundW-1:0] LastRound = 4'd10;

  // Request to the shared AES round unit
  typedef struct packed {
    logic              start;
    logic [BlockW-1:0] blk;
  } aes_req_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_SINGLE,
    S_SUM_RD,
    S_SUM_ACC,
    S_NODE_WR,
    S_EXP_RD,
    S_EXP_LD,
    S_EXP_AES,
    S_EXP_WR,
    S_FIN,
    S_EMIT_RD,
    S_EMIT_OUT
  } state_e;

  localparam logic [7:0] SboxTab [256] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] sub_byte(logic [7:0] b);
    return SboxTab[b];
  endfunction

  function automatic logic [7:0] xtime(logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Round constant for key schedule step r (1..10)
  function automatic logic [7:0] rcon(logic [RoundW-1:0] r);
    logic [7:0] c;
    case (r)
      4'd1:    c = 8'h01;
      4'd2:    c = 8'h02;
      4'd3:    c = 8'h04;
      4'd4:    c = 8'h08;
      4'd5:    c = 8'h10;
      4'd6:    c = 8'h20;
      4'd7:    c = 8'h40;
      4'd8:    c = 8'h80;
      4'd9:    c = 8'h1b;
      4'd10:   c = 8'h36;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Tree depth: smallest d with 2**d >= s
  function automatic logic [LvlW-1:0] ceil_log2(logic [SizeW-1:0] s);
    logic [LvlW-1:0] d;
    d = '0;
    for (int k = 0; k < SizeW; k++) begin
      if ((SizeW'(1) << k) < s) d = LvlW'(k + 1);
    end
    return d;
  endfunction

endpackage

// ----- hdl/pgte_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pgte_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/pgte_aes.sv -----
// Iterative AES-128 encryption unit: one round and one key schedule step per cycle.
// Depends on pgte_pkg for the S-box, round constants and the request struct.
module pgte_aes (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  pgte_pkg::aes_req_t         req_i,
  input  logic [pgte_pkg::BlockW-1:0] key_i,
  output logic                       done_o,
  output logic [pgte_pkg::BlockW-1:0] result_o
);

  logic [pgte_pkg::BlockW-1:0] st_q, st_d, rk_q, rk_d;
  logic [pgte_pkg::RoundW-1:0] rnd_q, rnd_d;
  logic                        run_q, run_d, done_q, done_d;

  // Next round key from the current one
  always_comb begin
    logic [7:0] t [4];
    logic [31:0] w0, w1, w2, w3;
    t[0] = pgte_pkg::sub_byte(rk_q[8*13 +: 8]) ^ pgte_pkg::rcon(rnd_q);
    t[1] = pgte_pkg::sub_byte(rk_q[8*14 +: 8]);
    t[2] = pgte_pkg::sub_byte(rk_q[8*15 +: 8]);
    t[3] = pgte_pkg::sub_byte(rk_q[8*12 +: 8]);
    w0 = rk_q[31:0] ^ {t[3], t[2], t[1], t[0]};
    w1 = rk_q[63:32] ^ w0;
    w2 = rk_q[95:64] ^ w1;
    w3 = rk_q[127:96] ^ w2;
    rk_d = {w3, w2, w1, w0};
  end

  // One cipher round: substitute, shift rows, mix columns (skipped in the last round), add round key
  always_comb begin
    logic [7:0] o [16];
    logic [7:0] s [16];
    logic [7:0] a0, a1, a2, a3;
    logic [pgte_pkg::BlockW-1:0] rnd_out;
    for (int i = 0; i < 16; i++) begin
      o[i] = pgte_pkg::sub_byte(st_q[8*i +: 8]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int i = 0; i < 4; i++) begin
        s[i + 4*c] = o[i + 4*((c + i) % 4)];
      end
    end
    for (int c = 0; c < 4; c++) begin
      a0 = s[4*c];
      a1 = s[4*c + 1];
      a2 = s[4*c + 2];
      a3 = s[4*c + 3];
      if (rnd_q != pgte_pkg::LastRound) begin
        rnd_out[32*c +: 8]      = pgte_pkg::xtime(a0) ^ pgte_pkg::xtime(a1) ^ a1 ^ a2 ^ a3;
        rnd_out[32*c + 8 +: 8]  = a0 ^ pgte_pkg::xtime(a1) ^ pgte_pkg::xtime(a2) ^ a2 ^ a3;
        rnd_out[32*c + 16 +: 8] = a0 ^ a1 ^ pgte_pkg::xtime(a2) ^ pgte_pkg::xtime(a3) ^ a3;
        rnd_out[32*c + 24 +: 8] = pgte_pkg::xtime(a0) ^ a0 ^ a1 ^ a2 ^ pgte_pkg::xtime(a3);
      end else begin
        rnd_out[32*c +: 8]      = a0;
        rnd_out[32*c + 8 +: 8]  = a1;
        rnd_out[32*c + 16 +: 8] = a2;
        rnd_out[32*c + 24 +: 8] = a3;
      end
    end
    st_d = rnd_out ^ rk_d;
  end

  // Round sequencing
  always_comb begin
    rnd_d  = rnd_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rnd_d = 4'd1;
      run_d = 1'b1;
    end else if (run_q) begin
      rnd_d = rnd_q + 4'd1;
      if (rnd_q == pgte_pkg::LastRound) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q  <= '0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rnd_q  <= rnd_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  // State and round key load on start and hold after the last round
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      st_q <= req_i.blk ^ key_i;
      rk_q <= key_i;
    end else if (run_q) begin
      st_q <= st_d;
      rk_q <= rk_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = st_q;

endmodule

// ----- hdl/punctured_ggm_tree_expand.sv -----
// Punctured GGM tree rebuild: one level word per start, leaves streamed after the last level.
// A single-leaf size strobes its leaf in the cycle after start. A level word reads and sums the
// same-parity nodes, expands each new node with two PRF calls on the shared 10-round AES unit
// and, after the last level, streams out its leaves; a 64-leaf query takes six words.
// busy stays high until the word is done.
// Reset clears control state and node valid bits at once; leaves are strobed and never stall.
module punctured_ggm_tree_expand #(
  parameter int unsigned MAX_LEAVES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic [pgte_pkg::WordW-1:0]  msg_lo_i,
  input  logic [pgte_pkg::WordW-1:0]  msg_hi_i,
  input  logic [pgte_pkg::WordW-1:0]  fix0_lo_i,
  input  logic [pgte_pkg::WordW-1:0]  fix0_hi_i,
  input  logic [pgte_pkg::WordW-1:0]  fix1_lo_i,
  input  logic [pgte_pkg::WordW-1:0]  fix1_hi_i,
  input  logic                        choice_bit_i,
  input  logic [pgte_pkg::IdxW-1:0]   punct_index_i,
  input  logic                        last_level_i,
  output logic                        leaf_valid_o,
  output logic [pgte_pkg::WordW-1:0]  leaf_lo_o,
  output logic [pgte_pkg::WordW-1:0]  leaf_hi_o,
  output logic [pgte_pkg::IdxW-1:0]   leaf_index_o,
  output logic                        last_leaf_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [1:0]                  cfg_index_i,
  input  logic [pgte_pkg::WordW-1:0]  cfg_data_i
);

  localparam int unsigned CntW       = $clog2(MAX_LEAVES);
  localparam int unsigned NodeW      = CntW + 1;
  localparam int unsigned StoreDepth = 2 ** NodeW;

  pgte_pkg::state_e state_q, state_d;

  logic [pgte_pkg::WordW-1:0]  key_lo_q, key_hi_q;
  logic [pgte_pkg::SizeW-1:0]  active_q;
  logic [pgte_pkg::LvlW-1:0]   level_q, lvl_q, m_q;
  logic [NodeW-1:0]            path_q, node_q, n_q, first_q, end_q;
  logic [CntW-1:0]             cnt_q;
  logic                        choice_q, last_q, c_q;
  logic [pgte_pkg::IdxW-1:0]   punct_q;
  logic [pgte_pkg::BlockW-1:0] acc_q, x_q;
  logic [StoreDepth-1:0]       vld_q;
  logic                        vld_rd_q;

  logic                        accept;
  logic [pgte_pkg::SizeW-1:0]  size_w;
  logic [pgte_pkg::LvlW-1:0]   depth_w, lvl_w;
  logic [NodeW-1:0]            path_eff, sum_addr, emit_addr, rd_addr, wr_addr;
  logic [pgte_pkg::BlockW-1:0] rd_masked, wr_data, aes_out;
  logic [pgte_pkg::WordW-1:0]  rd_lo, rd_hi;
  logic                        wr_en, sum_end, grp_end, emit_end, aes_done;
  pgte_pkg::aes_req_t          aes_req;

  // Effective size, depth and level of the incoming word
  assign size_w = (active_q == '0) ? pgte_pkg::SizeW'(1) :
                  (active_q > pgte_pkg::SizeW'(MAX_LEAVES)) ? pgte_pkg::SizeW'(MAX_LEAVES) :
                  active_q;
  assign depth_w  = pgte_pkg::ceil_log2(size_w);
  assign lvl_w    = level_q + pgte_pkg::LvlW'(1);
  assign accept   = start && (state_q == pgte_pkg::S_IDLE);
  assign busy     = (state_q != pgte_pkg::S_IDLE);
  assign path_eff = (level_q == '0) ? NodeW'(1) : path_q;

  assign sum_addr  = (NodeW'(1) << lvl_q) | NodeW'(cnt_q);
  assign emit_addr = (NodeW'(1) << depth_w) | NodeW'(cnt_q);
  assign sum_end   = ((({1'b0, cnt_q} + (CntW + 1)'(2)) >> lvl_q) != '0);
  assign grp_end   = ((n_q + NodeW'(1)) == end_q);
  assign emit_end  = ((pgte_pkg::SizeW'(cnt_q) + pgte_pkg::SizeW'(1)) == size_w);
  assign rd_masked = vld_rd_q ? {rd_hi, rd_lo} : '0;
  // Take configuration only while idle and no word is offered
  assign cfg_ready_o = (state_q == pgte_pkg::S_IDLE) && !start;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pgte_pkg::S_IDLE: begin
        if (start) begin
          if (size_w == pgte_pkg::SizeW'(1)) state_d = pgte_pkg::S_SINGLE;
          else if (lvl_w <= depth_w)        state_d = pgte_pkg::S_SUM_RD;
          else if (last_level_i)            state_d = pgte_pkg::S_EMIT_RD;
        end
      end
      pgte_pkg::S_SINGLE:  state_d = pgte_pkg::S_IDLE;
      pgte_pkg::S_SUM_RD:  state_d = pgte_pkg::S_SUM_ACC;
      pgte_pkg::S_SUM_ACC: state_d = sum_end ? pgte_pkg::S_NODE_WR : pgte_pkg::S_SUM_RD;
      pgte_pkg::S_NODE_WR: state_d = (lvl_q == depth_w) ? pgte_pkg::S_FIN : pgte_pkg::S_EXP_RD;
      pgte_pkg::S_EXP_RD:  state_d = pgte_pkg::S_EXP_LD;
      pgte_pkg::S_EXP_LD:  state_d = pgte_pkg::S_EXP_AES;
      pgte_pkg::S_EXP_AES: begin
        if (aes_done) state_d = pgte_pkg::S_EXP_WR;
      end
      pgte_pkg::S_EXP_WR: begin
        if (!c_q) state_d = pgte_pkg::S_EXP_AES;
        else if (grp_end && (m_q + pgte_pkg::LvlW'(1) == depth_w)) state_d = pgte_pkg::S_FIN;
        else state_d = pgte_pkg::S_EXP_RD;
      end
      pgte_pkg::S_FIN:      state_d = last_q ? pgte_pkg::S_EMIT_RD : pgte_pkg::S_IDLE;
      pgte_pkg::S_EMIT_RD:  state_d = pgte_pkg::S_EMIT_OUT;
      pgte_pkg::S_EMIT_OUT: state_d = emit_end ? pgte_pkg::S_IDLE : pgte_pkg::S_EMIT_RD;
      default:              state_d = pgte_pkg::S_IDLE;
    endcase
  end

  // Store access, AES requests and leaf outputs
  always_comb begin
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = node_q;
    wr_data      = acc_q;
    aes_req      = '0;
    leaf_valid_o = 1'b0;
    leaf_lo_o    = '0;
    leaf_hi_o    = '0;
    leaf_index_o = '0;
    last_leaf_o  = 1'b0;
    unique case (state_q)
      pgte_pkg::S_SUM_RD:  rd_addr = sum_addr;
      pgte_pkg::S_NODE_WR: wr_en   = 1'b1;
      pgte_pkg::S_EXP_RD:  rd_addr = n_q;
      pgte_pkg::S_EXP_LD: begin
        aes_req.start = 1'b1;
        aes_req.blk   = rd_masked;
      end
      pgte_pkg::S_EXP_WR: begin
        wr_en   = 1'b1;
        wr_addr = {n_q[CntW-1:0], c_q};
        wr_data = aes_out ^ x_q;
        if (!c_q) begin
          aes_req.start = 1'b1;
          aes_req.blk   = {x_q[pgte_pkg::BlockW-1:1], ~x_q[0]};
        end
      end
      pgte_pkg::S_EMIT_RD: rd_addr = emit_addr;
      pgte_pkg::S_EMIT_OUT: begin
        leaf_valid_o = 1'b1;
        if (pgte_pkg::IdxW'(cnt_q) != punct_q) begin
          leaf_lo_o = rd_masked[pgte_pkg::WordW-1:0];
          leaf_hi_o = rd_masked[pgte_pkg::BlockW-1:pgte_pkg::WordW];
        end
        leaf_index_o = pgte_pkg::IdxW'(cnt_q);
        last_leaf_o  = emit_end;
      end
      pgte_pkg::S_SINGLE: begin
        leaf_valid_o = 1'b1;
        leaf_lo_o    = acc_q[pgte_pkg::WordW-1:0];
        leaf_hi_o    = acc_q[pgte_pkg::BlockW-1:pgte_pkg::WordW];
        last_leaf_o  = 1'b1;
      end
      default: rd_addr = '0;
    endcase
  end

  // Control state: sequencer, configuration, query progress, node valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= pgte_pkg::S_IDLE;
      key_lo_q <= '0;
      key_hi_q <= '0;
      active_q <= pgte_pkg::SizeW'(64);
      level_q  <= '0;
      path_q   <= NodeW'(1);
      vld_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          pgte_pkg::CfgKeyLo:  key_lo_q <= cfg_data_i;
          pgte_pkg::CfgKeyHi:  key_hi_q <= cfg_data_i;
          pgte_pkg::CfgActive: active_q <= cfg_data_i[pgte_pkg::SizeW-1:0];
          default:             active_q <= active_q;
        endcase
      end
      if (accept) begin
        if (size_w == pgte_pkg::SizeW'(1)) begin
          level_q <= '0;
          path_q  <= NodeW'(1);
        end else begin
          path_q <= path_eff;
          if (level_q == '0) vld_q <= '0;
        end
      end
      if (wr_en) vld_q[wr_addr] <= 1'b1;
      if (state_q == pgte_pkg::S_FIN) begin
        path_q  <= {path_q[NodeW-2:0], ~choice_q};
        level_q <= lvl_q;
      end
      if (state_q == pgte_pkg::S_EMIT_OUT && emit_end) begin
        level_q <= '0;
        path_q  <= NodeW'(1);
      end
    end
  end

  // Datapath registers of the word in flight
  always_ff @(posedge clk_i) begin
    vld_rd_q <= vld_q[rd_addr];
    if (accept) begin
      choice_q <= choice_bit_i;
      last_q   <= last_level_i;
      punct_q  <= punct_index_i;
      lvl_q    <= lvl_w;
      node_q   <= {path_eff[NodeW-2:0], choice_bit_i};
      cnt_q    <= (lvl_w <= depth_w) ? CntW'(choice_bit_i) : '0;
      if (size_w == pgte_pkg::SizeW'(1)) begin
        acc_q <= {msg_hi_i, msg_lo_i};
      end else begin
        acc_q <= {msg_hi_i, msg_lo_i} ^
                 (choice_bit_i ? {fix1_hi_i, fix1_lo_i} : {fix0_hi_i, fix0_lo_i});
      end
    end
    unique case (state_q)
      pgte_pkg::S_SUM_ACC: begin
        if (sum_addr != node_q) acc_q <= acc_q ^ rd_masked;
        if (!sum_end) cnt_q <= cnt_q + CntW'(2);
      end
      pgte_pkg::S_NODE_WR: begin
        m_q     <= lvl_q;
        n_q     <= node_q;
        first_q <= node_q;
        end_q   <= node_q + NodeW'(1);
      end
      pgte_pkg::S_EXP_LD: begin
        x_q <= rd_masked;
        c_q <= 1'b0;
      end
      pgte_pkg::S_EXP_WR: begin
        if (!c_q) begin
          c_q <= 1'b1;
          x_q <= {x_q[pgte_pkg::BlockW-1:1], ~x_q[0]};
        end else if (grp_end) begin
          m_q     <= m_q + pgte_pkg::LvlW'(1);
          first_q <= first_q << 1;
          end_q   <= end_q << 1;
          n_q     <= first_q << 1;
        end else begin
          n_q <= n_q + NodeW'(1);
        end
      end
      pgte_pkg::S_FIN:      cnt_q <= '0;
      pgte_pkg::S_EMIT_OUT: cnt_q <= cnt_q + CntW'(1);
      default: ;
    endcase
  end

  pgte_ram #(.Width(pgte_pkg::WordW), .Depth(StoreDepth)) u_ram_lo (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data[pgte_pkg::WordW-1:0]),
    .raddr_i (rd_addr),
    .rdata_o (rd_lo)
  );

  pgte_ram #(.Width(pgte_pkg::WordW), .Depth(StoreDepth)) u_ram_hi (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (wr_data[pgte_pkg::BlockW-1:pgte_pkg::WordW]),
    .raddr_i (rd_addr),
    .rdata_o (rd_hi)
  );

  pgte_aes u_aes (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (aes_req),
    .key_i    ({key_hi_q, key_lo_q}),
    .done_o   (aes_done),
    .result_o (aes_out)
  );

`ifndef SYNTHESIS
  // An accepted last-level word keeps the block busy in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && last_level_i) |=> busy)
    else $error("accepted word did not raise busy");

  // The final leaf ends the word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (leaf_valid_o && last_leaf_o) |=> !busy)
    else $error("block stayed busy after the final leaf");

  // AES completion only arrives while the sequencer waits for it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    aes_done |-> (state_q == pgte_pkg::S_EXP_AES))
    else $error("AES done outside the wait state");

  // No store write while leaves stream out
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    leaf_valid_o |-> !wr_en)
    else $error("store write during leaf output");
`endif

endmodule
